// File: sv/power_series_mul_inv_div_assert.svh
// Assertion macros for the power-series block checker.
// Included by the checker file only; no other dependencies.
`ifndef POWER_SERIES_MUL_INV_DIV_ASSERT_SVH
`define POWER_SERIES_MUL_INV_DIV_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define PSMID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define PSMID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/psmid_pkg.sv
// Shared constants and types for the power-series multiply/invert/divide block.
// No dependencies.
package psmid_pkg;

  localparam int ORDER_DEF = 64;
  localparam int COEFF_W   = 64;
  localparam int HALF_W    = 32;
  localparam int DEG_W     = 6;
  localparam int MODE_W    = 2;
  localparam int IN_DATA_W  = 2 * COEFF_W;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  localparam logic [MODE_W-1:0] MODE_MUL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INV = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIV = 2'd2;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_WR       = 12'b0000_0000_0010,
    ST_INV_CHK  = 12'b0000_0000_0100,
    ST_W_ADDR   = 12'b0000_0000_1000,
    ST_W_M0     = 12'b0000_0001_0000,
    ST_W_M1     = 12'b0000_0010_0000,
    ST_W_M2     = 12'b0000_0100_0000,
    ST_W_M3     = 12'b0000_1000_0000,
    ST_DIV      = 12'b0001_0000_0000,
    ST_INV_WR   = 12'b0010_0000_0000,
    ST_PROD_CHK = 12'b0100_0000_0000,
    ST_DONE     = 12'b1000_0000_0000
  } psmid_state_t;

endpackage

// File: sv/power_series_mul_inv_div.sv
// Truncated power-series multiply / invert / divide, one coefficient in, one out.
// Depends on psmid_pkg, psmid_ram and psmid_div.
//
// Coefficients arrive lowest degree first; each input transfer yields one result
// transfer at the same degree, and the inverse is built in every mode. Every term
// of a convolution walk uses the single shared 32x32 multiplier (a read-address
// step, three partial products and a final accumulate), and each inverse
// coefficient waits on a 64-step one-bit-per-step divider. A zero constant term
// skips the inverse walk and the divider. An item past the order goes straight
// from idle to the done state.
// The block accepts no input while an item is at work; a finished result waits
// in the output register while the next input is taken.
module power_series_mul_inv_div import psmid_pkg::*; #(
  parameter int ORDER = ORDER_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // first_coeff, second_coeff
  input  logic                  in_tuser,   // restart
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_coeff, degree, zero pad
  output logic [OUT_USER_W-1:0] out_tuser,  // zero_divisor, past_order
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [MODE_W-1:0]     cfg_data
);

  localparam int IW = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int CW = $clog2(ORDER + 1);

  psmid_state_t state_r, state_nxt;

  logic [MODE_W-1:0]  mode_r;
  logic [CW-1:0]      cnt_r;
  logic [IW-1:0]      d_r;
  logic [IW-1:0]      i_r;
  logic [IW-1:0]      j;
  logic [COEFF_W-1:0] a_r, b_r, f0_r, s0_r;
  logic [COEFF_W-1:0] opa_r, opb_r, p_r, acc_r, acc_sum;
  logic [COEFF_W-1:0] inv_val_r, res_r, x0;
  logic               zero_r, po_r, walk_prod_r;
  logic [COEFF_W-1:0] first_rd, second_rd, inv_rd, rd_a, rd_b;
  logic [HALF_W-1:0]  mul_a, mul_b;
  logic [COEFF_W-1:0] mul_p;
  logic [CW-1:0]      d_in;
  logic               in_xfer, walk_end;
  logic               div_start, div_done;
  logic [COEFF_W-1:0] div_dividend, div_quot;
  logic [COEFF_W-1:0] out_res_r;
  logic [IW-1:0]      out_deg_r;
  logic               out_zd_r, out_po_r, out_valid_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_xfer    = in_tvalid && in_tready;
  assign d_in       = in_tuser ? '0 : cnt_r;
  assign j          = d_r - i_r;
  assign x0         = (mode_r == MODE_DIV) ? s0_r : f0_r;
  assign acc_sum    = acc_r + p_r;
  assign walk_end   = (i_r == d_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, DEG_W'(out_deg_r), out_res_r};
  assign out_tuser  = {out_po_r, out_zd_r};

  psmid_ram #(.WIDTH(COEFF_W), .DEPTH(ORDER)) u_first_ram (
    .clk(clk), .we(state_r == ST_WR), .waddr(d_r), .wdata(a_r),
    .raddr(i_r), .rdata(first_rd)
  );

  psmid_ram #(.WIDTH(COEFF_W), .DEPTH(ORDER)) u_second_ram (
    .clk(clk), .we(state_r == ST_WR), .waddr(d_r), .wdata(b_r),
    .raddr(walk_prod_r ? j : i_r), .rdata(second_rd)
  );

  psmid_ram #(.WIDTH(COEFF_W), .DEPTH(ORDER)) u_inv_ram (
    .clk(clk), .we(state_r == ST_INV_WR), .waddr(d_r), .wdata(inv_val_r),
    .raddr(j), .rdata(inv_rd)
  );

  assign rd_a = (!walk_prod_r && mode_r == MODE_DIV) ? second_rd : first_rd;
  assign rd_b = (!walk_prod_r || mode_r == MODE_DIV) ? inv_rd : second_rd;

  always_comb begin
    unique case (state_r)
      ST_W_M1: begin
        mul_a = opa_r[HALF_W-1:0];
        mul_b = opb_r[COEFF_W-1:HALF_W];
      end
      ST_W_M2: begin
        mul_a = opa_r[COEFF_W-1:HALF_W];
        mul_b = opb_r[HALF_W-1:0];
      end
      ST_W_M0: begin
        mul_a = rd_a[HALF_W-1:0];
        mul_b = rd_b[HALF_W-1:0];
      end
      default: begin
        mul_a = opa_r[HALF_W-1:0];
        mul_b = opb_r[HALF_W-1:0];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_start = ((state_r == ST_INV_CHK) && (x0 != '0) && (d_r == '0))
                  || ((state_r == ST_W_M3) && walk_end && !walk_prod_r);
  assign div_dividend = (state_r == ST_INV_CHK) ? COEFF_W'(1)
                                                : (COEFF_W'(0) - acc_sum);

  psmid_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_dividend), .divisor(x0),
    .done(div_done), .quot(div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (d_in >= CW'(ORDER)) ? ST_DONE : ST_WR;
        end
      end
      ST_WR:    state_nxt = ST_INV_CHK;
      ST_INV_CHK: begin
        if (x0 == '0) begin
          state_nxt = ST_INV_WR;
        end else if (d_r == '0) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_W_ADDR;
        end
      end
      ST_W_ADDR: state_nxt = ST_W_M0;
      ST_W_M0:   state_nxt = ST_W_M1;
      ST_W_M1:   state_nxt = ST_W_M2;
      ST_W_M2:   state_nxt = ST_W_M3;
      ST_W_M3: begin
        if (!walk_end) begin
          state_nxt = ST_W_ADDR;
        end else begin
          state_nxt = walk_prod_r ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV:    state_nxt = div_done ? ST_INV_WR : ST_DIV;
      ST_INV_WR: state_nxt = ST_PROD_CHK;
      ST_PROD_CHK: begin
        if (mode_r == MODE_INV || (mode_r == MODE_DIV && zero_r)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_W_ADDR;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_MUL;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (in_xfer && (d_in < CW'(ORDER))) begin
        cnt_r <= d_in + CW'(1);
      end else if (in_xfer) begin
        cnt_r <= d_in;
      end
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          a_r    <= in_tdata[COEFF_W-1:0];
          b_r    <= in_tdata[IN_DATA_W-1:COEFF_W];
          d_r    <= IW'(d_in);
          zero_r <= 1'b0;
          po_r   <= (d_in >= CW'(ORDER));
          res_r  <= '0;
        end
      end
      ST_WR: begin
        if (d_r == '0) begin
          f0_r <= a_r;
          s0_r <= b_r;
        end
      end
      ST_INV_CHK: begin
        walk_prod_r <= 1'b0;
        i_r         <= IW'(1);
        acc_r       <= '0;
        if (x0 == '0) begin
          zero_r    <= 1'b1;
          inv_val_r <= '0;
        end
      end
      ST_W_M0: begin
        opa_r <= rd_a;
        opb_r <= rd_b;
        p_r   <= mul_p;
      end
      ST_W_M1, ST_W_M2: begin
        acc_r <= acc_sum;
        p_r   <= {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
      end
      ST_W_M3: begin
        acc_r <= acc_sum;
        i_r   <= i_r + IW'(1);
        if (walk_end && walk_prod_r) begin
          res_r <= acc_sum;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          inv_val_r <= div_quot;
        end
      end
      ST_PROD_CHK: begin
        walk_prod_r <= 1'b1;
        i_r         <= '0;
        acc_r       <= '0;
        if (mode_r == MODE_INV) begin
          res_r <= zero_r ? '0 : inv_val_r;
        end else if (mode_r != MODE_DIV) begin
          zero_r <= 1'b0;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_res_r <= res_r;
          out_deg_r <= po_r ? '0 : d_r;
          out_zd_r  <= zero_r;
          out_po_r  <= po_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/psmid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psmid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/psmid_div.sv
// Signed 64-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on psmid_pkg.
module psmid_div import psmid_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COEFF_W-1:0] dividend,
  input  logic [COEFF_W-1:0] divisor,
  output logic               done,
  output logic [COEFF_W-1:0] quot
);

  localparam int SW = $clog2(COEFF_W + 1);

  logic [COEFF_W-1:0] q_r;
  logic [COEFF_W-1:0] rem_r;
  logic [COEFF_W-1:0] mb_r;
  logic               neg_r;
  logic               busy_r;
  logic               done_r;
  logic [SW-1:0]      step_r;
  logic [COEFF_W:0]   rem_sh;
  logic               fits;

  assign rem_sh = {rem_r, q_r[COEFF_W-1]};
  assign fits   = rem_sh >= {1'b0, mb_r};
  assign quot   = neg_r ? (COEFF_W'(0) - q_r) : q_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(COEFF_W);
      end else if (busy_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend[COEFF_W-1] ? (COEFF_W'(0) - dividend) : dividend;
      mb_r  <= divisor[COEFF_W-1] ? (COEFF_W'(0) - divisor) : divisor;
      neg_r <= dividend[COEFF_W-1] ^ divisor[COEFF_W-1];
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? COEFF_W'(rem_sh - {1'b0, mb_r}) : rem_sh[COEFF_W-1:0];
      q_r   <= {q_r[COEFF_W-2:0], fits};
    end
  end

endmodule

// File: sv/psmid_chk.sv
// Port-level checker for the power-series block, bound to the top level.
// Depends on psmid_pkg and power_series_mul_inv_div_assert.svh.
`include "power_series_mul_inv_div_assert.svh"

module psmid_chk import psmid_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  `PSMID_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "ready after transfer")
  `PSMID_ASSERT_NOW(a_past_order_zero, out_tvalid && out_tuser[1], out_tdata == '0 && !out_tuser[0], "past order result not zero")
  `PSMID_ASSERT_NOW(a_zero_div_zero, out_tvalid && out_tuser[0], out_tdata[COEFF_W-1:0] == '0, "zero divisor result not zero")
  `PSMID_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind power_series_mul_inv_div psmid_chk u_psmid_chk (.*);

// File: test/tb_power_series_mul_inv_div.sv
// Testbench for power_series_mul_inv_div: multiply, invert and divide of truncated series.
// Drives random and directed coefficient streams, predicts each result in a scoreboard.
// Depends on psmid_pkg and the block itself.
module tb_power_series_mul_inv_div;
  import psmid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] coeff;
    logic [5:0]  degree;
    logic        zero_div;
    logic        past;
  } series_result_t;

  class series_scoreboard;
    logic [63:0] first_hist[ORDER_DEF];
    logic [63:0] second_hist[ORDER_DEF];
    logic [63:0] inv_hist[ORDER_DEF];
    int unsigned next_degree;
    logic [1:0] mode;
    series_result_t pending[$];
    int mismatches;

    function new();
      next_degree = 0;
      mode = MODE_MUL;
      mismatches = 0;
    endfunction

    function logic [63:0] quotient(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
    endfunction

    function void note_input(logic [63:0] f, logic [63:0] s, logic rs);
      series_result_t r;
      int unsigned d;
      logic [63:0] acc, pivot;
      logic zero;
      if (rs) next_degree = 0;
      r.coeff = '0; r.degree = '0; r.zero_div = 1'b0; r.past = 1'b0;
      if (next_degree >= ORDER_DEF) begin
        r.past = 1'b1;
        pending.push_back(r);
        return;
      end
      d = next_degree;
      first_hist[d] = f;
      second_hist[d] = s;
      pivot = (mode == MODE_DIV) ? second_hist[0] : first_hist[0];
      zero = (pivot == 0);
      if (zero) begin
        inv_hist[d] = '0;
      end else if (d == 0) begin
        inv_hist[0] = quotient(64'd1, pivot);
      end else begin
        acc = '0;
        for (int i = 1; i <= d; i++)
          acc += ((mode == MODE_DIV) ? second_hist[i] : first_hist[i]) * inv_hist[d-i];
        inv_hist[d] = quotient(-acc, pivot);
      end
      acc = '0;
      if (mode == MODE_INV) begin
        acc = zero ? '0 : inv_hist[d];
      end else if (mode == MODE_DIV) begin
        if (!zero) for (int i = 0; i <= d; i++) acc += first_hist[i] * inv_hist[d-i];
      end else begin
        zero = 1'b0;
        for (int i = 0; i <= d; i++) acc += first_hist[i] * second_hist[d-i];
      end
      r.coeff = acc;
      r.degree = d[5:0];
      r.zero_div = zero;
      next_degree = d + 1;
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] c, logic [5:0] d, logic z, logic p);
      series_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: coeff %h deg %0d", c, d);
        return;
      end
      e = pending.pop_front();
      if (c !== e.coeff || d !== e.degree || z !== e.zero_div || p !== e.past) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                   e.coeff, e.degree, e.zero_div, e.past, c, d, z, p);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MODE_W-1:0] cfg_data = '0;

  series_scoreboard board;
  int idle_pct_in = 35;
  int idle_pct_out = 35;
  int hold_out = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 10000000;

  power_series_mul_inv_div uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata[63:0], out_tdata[69:64], out_tuser[0], out_tuser[1]);
  end

  always @(negedge clk) begin
    if (hold_out > 0) begin
      hold_out--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct_out);
    end
  end

  task automatic send_item(logic [63:0] f, logic [63:0] s, logic rs);
    while ($urandom_range(99) < idle_pct_in) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {s, f};
    in_tuser <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(f, s, rs);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_coeff();
    case ($urandom_range(5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return {$urandom, $urandom};
      3: return 64'(signed'($urandom_range(6)) - 3);
      default: return 64'(signed'($urandom_range(40)) - 20);
    endcase
  endfunction

  task automatic send_series(int len, bit zero_lead);
    logic [63:0] f, s;
    for (int k = 0; k < len; k++) begin
      f = rand_coeff();
      s = rand_coeff();
      if (k == 0 && !zero_lead) begin
        if (f == 0) f = 64'd1;
        if (s == 0) s = 64'hffff_ffff_ffff_ffff;
        if ($urandom_range(1)) begin
          f = $urandom_range(1) ? 64'd1 : 64'hffff_ffff_ffff_ffff;
          s = $urandom_range(1) ? 64'd1 : 64'hffff_ffff_ffff_ffff;
        end
      end
      send_item(f, s, k == 0 ? 1'b1 : ($urandom_range(199) == 0));
    end
  endtask

  initial begin
    int sent;
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(64'd3, 64'd5, 1'b0);
    send_item(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 1'b0);
    send_item(64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 1'b0);
    write_mode(MODE_INV);
    send_item(64'd0, 64'd7, 1'b1);
    send_item(64'd4, 64'd7, 1'b0);
    send_item(64'd1, 64'd0, 1'b1);
    send_item(64'd2, 64'd0, 1'b0);
    send_item(64'hffff_ffff_ffff_fffe, 64'd0, 1'b0);
    write_mode(MODE_DIV);
    send_item(64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 1'b1);
    send_item(64'd9, 64'd3, 1'b0);
    send_item(64'd5, 64'd0, 1'b1);
    send_item(64'd5, 64'd2, 1'b0);
    send_item(64'd1, 64'd1, 1'b1);
    write_mode(MODE_INV);
    send_item(64'd6, 64'd1, 1'b0);
    write_mode(2'd3);
    send_item(64'd2, 64'd3, 1'b1);
    send_item(64'd4, 64'd5, 1'b0);
    write_mode(MODE_MUL);
    send_series(66, 1'b0);
    send_item(64'd1, 64'd1, 1'b0);
    send_item(64'd1, 64'd1, 1'b1);

    sent = 0;
    for (int ph = 0; sent < 1800; ph++) begin
      write_mode(2'($urandom_range(3)));
      if (ph == 2) begin
        idle_pct_in = 0;
        idle_pct_out = 0;
      end else if (ph == 3) begin
        idle_pct_in = 35;
        idle_pct_out = 35;
        hold_out = 3000;
      end
      for (int k = 0; k < 4 && sent < 1800; k++) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 16);
        send_series(len, $urandom_range(9) == 0);
        sent += len;
        if ($urandom_range(7) == 0) begin
          send_item(rand_coeff(), rand_coeff(), 1'b0);
          sent++;
        end
      end
    end

    drain();
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/psmid_pkg.sv
sv/psmid_ram.sv
sv/psmid_div.sv
sv/power_series_mul_inv_div.sv
sv/psmid_chk.sv
test/tb_power_series_mul_inv_div.sv
